>>> src/sfas_pkg.sv
// Package for the small float adder/subtractor.
// Holds the command encoding; no dependencies.
package sfas_pkg;
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_e;
endpackage

>>> src/small_float_add_sub_top.sv
// Top level of the small float adder/subtractor: a four-stage pipeline.
// Depends on sfas_pkg for the command encoding.
//
//   channel | signals                                      | direction
//   in      | valid_i ready_o command_i operand_a/b_i      | input beat
//   out     | valid_o ready_i result_o exponent_out_of_range_o | output beat
//
// One beat enters per cycle unless stalled; stages: decode, align, add, normalize.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall holds the full stages at the output end; a bubble is filled while stalled.
module small_float_add_sub_top #(
  parameter int EXPONENT_WIDTH = 8,
  parameter int FRACTION_WIDTH = 7
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  sfas_pkg::cmd_e                          command_i,
  input  logic [EXPONENT_WIDTH+FRACTION_WIDTH:0]  operand_a_i,
  input  logic [EXPONENT_WIDTH+FRACTION_WIDTH:0]  operand_b_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [EXPONENT_WIDTH+FRACTION_WIDTH:0]  result_o,
  output logic                                    exponent_out_of_range_o
);
  import sfas_pkg::*;

  localparam int EW = EXPONENT_WIDTH;
  localparam int FW = FRACTION_WIDTH;
  localparam int W  = EW + FW + 1;
  localparam int SP = EW + FW;
  localparam int MW = FW + 3;            // signed significand plus carry
  localparam int XW = EW + 2;            // signed exponent with headroom
  localparam int LW = $clog2(MW + 1);

  logic [3:0] vld_q;
  logic [3:0] adv;

  assign adv[3] = ~vld_q[3] | ready_i;
  assign adv[2] = ~vld_q[2] | adv[3];
  assign adv[1] = ~vld_q[1] | adv[2];
  assign adv[0] = ~vld_q[0] | adv[1];
  assign ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Stage 0: flip, special cases, signed significands.
  logic [W-1:0]  b_flip;
  logic          spec_d, spec_q;
  logic [W-1:0]  spec_res_d, spec_res_q;
  logic signed [MW-1:0] sa0_d, sa0_q, sb0_d, sb0_q;
  logic [EW-1:0] ea_q, eb_q;

  always_comb begin
    b_flip = operand_b_i;
    if (command_i == CMD_SUB && operand_b_i != '0) b_flip[SP] = ~operand_b_i[SP];
    spec_d = 1'b1;
    spec_res_d = '0;
    if (operand_a_i == '0) spec_res_d = b_flip;
    else if (b_flip == '0) spec_res_d = operand_a_i;
    else if (operand_a_i == (b_flip ^ (W'(1) << SP))) spec_res_d = '0;
    else spec_d = 1'b0;
    sa0_d = MW'({1'b1, operand_a_i[FW-1:0]});
    sb0_d = MW'({1'b1, b_flip[FW-1:0]});
    if (operand_a_i[SP]) sa0_d = -sa0_d;
    if (b_flip[SP]) sb0_d = -sb0_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      spec_q <= spec_d;
      spec_res_q <= spec_res_d;
      sa0_q <= sa0_d;
      sb0_q <= sb0_d;
      ea_q <= operand_a_i[SP-1:FW];
      eb_q <= b_flip[SP-1:FW];
    end
  end

  // Stage 1: align the smaller operand.
  logic signed [MW-1:0] sa1_d, sa1_q, sb1_d, sb1_q;
  logic [EW-1:0] ez1_d, ez1_q, align_sh;
  logic spec1_q;
  logic [W-1:0] spec_res1_q;

  always_comb begin
    sa1_d = sa0_q;
    sb1_d = sb0_q;
    ez1_d = ea_q;
    if (ea_q > eb_q) begin
      align_sh = ea_q - eb_q;
      sb1_d = sb0_q >>> align_sh;
    end else begin
      align_sh = eb_q - ea_q;
      ez1_d = eb_q;
      sa1_d = sa0_q >>> align_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sa1_q <= sa1_d;
      sb1_q <= sb1_d;
      ez1_q <= ez1_d;
      spec1_q <= spec_q;
      spec_res1_q <= spec_res_q;
    end
  end

  // Stage 2: add and take sign and magnitude.
  logic signed [MW-1:0] z;
  logic [MW-1:0] mag_d, mag_q;
  logic neg_q;
  logic [EW-1:0] ez2_q;
  logic spec2_q;
  logic [W-1:0] spec_res2_q;

  always_comb begin
    z = sa1_q + sb1_q;
    mag_d = z[MW-1] ? MW'(-z) : MW'(z);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      mag_q <= mag_d;
      neg_q <= z[MW-1];
      ez2_q <= ez1_q;
      spec2_q <= spec1_q;
      spec_res2_q <= spec_res1_q;
    end
  end

  // Stage 3: normalize and pack.
  logic [LW-1:0] lead;
  logic found;
  logic [MW-1:0] norm;
  logic signed [XW-1:0] ez3;
  logic [W-1:0] res_d, res_q;
  logic flag_d, flag_q;

  always_comb begin
    lead = '0;
    found = 1'b0;
    for (int i = 0; i < MW; i++) begin
      if (mag_q[i]) begin
        lead = LW'(i);
        found = 1'b1;
      end
    end
    norm = mag_q;
    ez3 = XW'({2'b00, ez2_q});
    if (found && lead > LW'(FW)) begin
      norm = mag_q >> (lead - LW'(FW));
      ez3 = ez3 + XW'(lead) - XW'(FW);
    end else if (found && lead < LW'(FW)) begin
      norm = mag_q << (LW'(FW) - lead);
      ez3 = ez3 - XW'(FW) + XW'(lead);
    end
    flag_d = 1'b0;
    if (spec2_q) begin
      res_d = spec_res2_q;
    end else begin
      flag_d = ez3[XW-1] | ez3[XW-2];
      res_d = {neg_q & found, ez3[EW-1:0], norm[FW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      res_q <= res_d;
      flag_q <= flag_d;
    end
  end

  assign valid_o = vld_q[3];
  assign result_o = res_q;
  assign exponent_out_of_range_o = flag_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(result_o))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("input blocked with empty output");
  a_spec_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv[3] && vld_q[2] && spec2_q |=> !exponent_out_of_range_o)
    else $error("flag raised on special case");
endmodule
